@@ rtl/rlt_pkg.sv @@
// rlt_pkg: shared types, constants and tables for the rgb565 lab threshold classifier
// no dependencies
`default_nettype none
package rlt_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_L_LOWER = 3'd0,
    REG_L_UPPER = 3'd1,
    REG_A_LOWER = 3'd2,
    REG_A_UPPER = 3'd3,
    REG_B_LOWER = 3'd4,
    REG_B_UPPER = 3'd5
  } rlt_reg_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 10;

  // reset values of the bounds
  localparam logic signed [9:0] L_LOWER_RST = 10'sd0;
  localparam logic signed [9:0] L_UPPER_RST = 10'sd100;
  localparam logic signed [9:0] A_LOWER_RST = -10'sd128;
  localparam logic signed [9:0] A_UPPER_RST = 10'sd127;
  localparam logic signed [9:0] B_LOWER_RST = -10'sd128;
  localparam logic signed [9:0] B_UPPER_RST = 10'sd127;

  // default depth of the result queue (power of two)
  localparam int RLT_Q_DEPTH = 2;

  // xyz coefficients, 20 bit fraction
  localparam logic [29:0] CX_R = 30'd455026;
  localparam logic [29:0] CX_G = 30'd394489;
  localparam logic [29:0] CX_B = 30'd199046;
  localparam logic [29:0] CY_R = 30'd223002;
  localparam logic [29:0] CY_G = 30'd749900;
  localparam logic [29:0] CY_B = 30'd75675;
  localparam logic [29:0] CZ_R = 30'd18619;
  localparam logic [29:0] CZ_G = 30'd114786;
  localparam logic [29:0] CZ_B = 30'd915097;

  // cube root pipeline length, one result bit per stage
  localparam int ROOT_BITS = 10;
  // last index served by the linear segment of f(t)
  localparam int LOW_LAST = 9;

  // srgb decode curve scaled by 1024
  localparam logic [9:0] GAMMA_ROM [64] = '{
    10'd0,   10'd1,   10'd2,   10'd3,   10'd5,   10'd7,   10'd9,   10'd11,
    10'd14,  10'd17,  10'd21,  10'd25,  10'd30,  10'd34,  10'd40,  10'd45,
    10'd52,  10'd58,  10'd65,  10'd73,  10'd81,  10'd90,  10'd99,  10'd108,
    10'd118, 10'd129, 10'd140, 10'd152, 10'd164, 10'd177, 10'd190, 10'd204,
    10'd219, 10'd234, 10'd249, 10'd266, 10'd283, 10'd300, 10'd318, 10'd337,
    10'd356, 10'd376, 10'd397, 10'd418, 10'd440, 10'd463, 10'd486, 10'd510,
    10'd535, 10'd560, 10'd586, 10'd612, 10'd640, 10'd668, 10'd696, 10'd726,
    10'd756, 10'd787, 10'd819, 10'd851, 10'd884, 10'd918, 10'd952, 10'd987
  };

  // linear segment of f(t) for small indexes
  localparam logic [9:0] LAB_LOW_ROM [10] = '{
    10'd141, 10'd148, 10'd156, 10'd164, 10'd172,
    10'd180, 10'd187, 10'd195, 10'd203, 10'd211
  };

  typedef struct packed {
    logic signed [9:0] l_lower;
    logic signed [9:0] l_upper;
    logic signed [9:0] a_lower;
    logic signed [9:0] a_upper;
    logic signed [9:0] b_lower;
    logic signed [9:0] b_upper;
  } rlt_bounds_t;

  typedef struct packed {
    logic [6:0]        lightness;
    logic signed [9:0] chroma_a;
    logic signed [8:0] chroma_b;
    logic              in_range;
  } rlt_res_t;

endpackage
`default_nettype wire

@@ rtl/rlt_if.sv @@
// rlt_if: valid/ready channel interfaces for pixels, results and register writes
// depends on rlt_pkg
`default_nettype none
interface rlt_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_rgb565;
  modport source (output valid, output pixel_rgb565, input ready);
  modport sink   (input valid, input pixel_rgb565, output ready);
endinterface

interface rlt_res_if;
  logic              valid;
  logic              ready;
  logic [6:0]        lightness;
  logic signed [9:0] chroma_a;
  logic signed [8:0] chroma_b;
  logic              in_range;
  modport source (output valid, output lightness, output chroma_a, output chroma_b,
                  output in_range, input ready);
  modport sink   (input valid, input lightness, input chroma_a, input chroma_b,
                  input in_range, output ready);
endinterface

interface rlt_cfg_if
  import rlt_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/rlt_lab_f.sv @@
// rlt_lab_f: pipelined f(t) unit, one cube root bit per stage plus linear segment
// depends on rlt_pkg
`default_nettype none
module rlt_lab_f
  import rlt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       en,
  input  wire logic [9:0] idx_i,
  output logic [9:0]      idx_o,
  output logic [9:0]      f_o
);

  logic [9:0]  y_r  [ROOT_BITS];
  logic [19:0] y2_r [ROOT_BITS];
  logic [29:0] y3_r [ROOT_BITS];
  logic [9:0]  t_r  [ROOT_BITS];

  // each stage tries one root bit, keeping y, y^2 and y^3 by shifts and adds
  for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
    localparam int K = ROOT_BITS - 1 - s;
    logic [9:0]  y_in;
    logic [19:0] y2_in;
    logic [29:0] y3_in;
    logic [9:0]  t_in;
    logic [31:0] trial;
    logic        fit;

    if (s == 0) begin : g_first
      assign y_in  = '0;
      assign y2_in = '0;
      assign y3_in = '0;
      assign t_in  = idx_i;
    end else begin : g_next
      assign y_in  = y_r[s-1];
      assign y2_in = y2_r[s-1];
      assign y3_in = y3_r[s-1];
      assign t_in  = t_r[s-1];
    end

    // (y + 2^k)^3 against t * 2^20
    assign trial = 32'(y3_in) + ((32'(y2_in) * 32'd3) << K)
                 + ((32'(y_in) * 32'd3) << (2 * K)) + (32'd1 << (3 * K));
    assign fit   = trial <= {2'b00, t_in, 20'd0};

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[s] <= t_in;
        if (fit) begin
          y_r[s]  <= y_in | (10'd1 << K);
          y2_r[s] <= y2_in + (20'(y_in) << (K + 1)) + (20'd1 << (2 * K));
          y3_r[s] <= trial[29:0];
        end else begin
          y_r[s]  <= y_in;
          y2_r[s] <= y2_in;
          y3_r[s] <= y3_in;
        end
      end
    end
  end

  // dark indexes take the linear segment
  always_comb begin
    idx_o = t_r[ROOT_BITS-1];
    if (idx_o <= 10'(LOW_LAST)) begin
      f_o = LAB_LOW_ROM[idx_o[3:0]];
    end else begin
      f_o = y_r[ROOT_BITS-1];
    end
  end

endmodule
`default_nettype wire

@@ rtl/rlt_front.sv @@
// rlt_front: accepts pixels, linearizes, forms xyz and lab, checks the bounds
// depends on rlt_pkg, rlt_lab_f
`default_nettype none
module rlt_front
  import rlt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] pixel,
  input  wire rlt_bounds_t bounds,
  output logic             push_valid,
  input  wire logic        push_ready,
  output rlt_res_t         push_data
);

  localparam int NSTG = 3 + ROOT_BITS + 1;

  logic            en;
  logic [NSTG-1:0] v_r;
  logic [9:0]      gr_r, gg_r, gb_r;
  logic [29:0]     p_r [9];
  logic [9:0]      x_r, y_r, z_r;
  logic [31:0]     sx, sy, sz;
  logic [9:0]      fx, fy, fz, ix, iy, iz;
  logic signed [18:0] l_pre, l_pre_r, lv;
  logic signed [20:0] a_pre, a_pre_r, av, da;
  logic signed [19:0] b_pre, b_pre_r, bv, db;
  logic signed [10:0] l11, a11, b11;
  logic signed [10:0] ll11, lu11, al11, au11, bl11, bu11;

  // whole pipeline moves unless the last stage is held
  assign en         = !v_r[NSTG-1] || push_ready;
  assign in_ready   = en;
  assign push_valid = v_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NSTG-2:0], in_valid};
    end
  end

  // gamma lookup
  always_ff @(posedge clk) begin
    if (en) begin
      gr_r <= GAMMA_ROM[{pixel[15:11], 1'b0}];
      gg_r <= GAMMA_ROM[pixel[10:5]];
      gb_r <= GAMMA_ROM[{pixel[4:0], 1'b0}];
    end
  end

  // coefficient products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= CX_R * 30'(gr_r);
      p_r[1] <= CX_G * 30'(gg_r);
      p_r[2] <= CX_B * 30'(gb_r);
      p_r[3] <= CY_R * 30'(gr_r);
      p_r[4] <= CY_G * 30'(gg_r);
      p_r[5] <= CY_B * 30'(gb_r);
      p_r[6] <= CZ_R * 30'(gr_r);
      p_r[7] <= CZ_G * 30'(gg_r);
      p_r[8] <= CZ_B * 30'(gb_r);
    end
  end

  // xyz as dot products shifted by 20
  assign sx = 32'(p_r[0]) + 32'(p_r[1]) + 32'(p_r[2]);
  assign sy = 32'(p_r[3]) + 32'(p_r[4]) + 32'(p_r[5]);
  assign sz = 32'(p_r[6]) + 32'(p_r[7]) + 32'(p_r[8]);

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= sx[29:20];
      y_r <= sy[29:20];
      z_r <= sz[29:20];
    end
  end

  rlt_lab_f u_fx (.clk(clk), .en(en), .idx_i(x_r), .idx_o(ix), .f_o(fx));
  rlt_lab_f u_fy (.clk(clk), .en(en), .idx_i(y_r), .idx_o(iy), .f_o(fy));
  rlt_lab_f u_fz (.clk(clk), .en(en), .idx_i(z_r), .idx_o(iz), .f_o(fz));

  // scaled lab before the final shift
  always_comb begin
    da = signed'(21'(fx)) - signed'(21'(fy));
    db = signed'(20'(fy)) - signed'(20'(fz));
    if (iy > 10'(LOW_LAST)) begin
      l_pre = 19'(19'sd116 * signed'(19'(fy))) - 19'sd16384;
    end else begin
      l_pre = 19'(19'sd903 * signed'(19'(iy)));
    end
    a_pre = 21'(21'sd500 * da);
    b_pre = 20'(20'sd200 * db);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_pre_r <= l_pre;
      a_pre_r <= a_pre;
      b_pre_r <= b_pre;
    end
  end

  // floor shift and strict bound checks, bounds sign-extended to 11 bits
  always_comb begin
    lv   = l_pre_r >>> 10;
    av   = a_pre_r >>> 10;
    bv   = b_pre_r >>> 10;
    l11  = lv[10:0];
    a11  = av[10:0];
    b11  = bv[10:0];
    ll11 = {bounds.l_lower[9], bounds.l_lower};
    lu11 = {bounds.l_upper[9], bounds.l_upper};
    al11 = {bounds.a_lower[9], bounds.a_lower};
    au11 = {bounds.a_upper[9], bounds.a_upper};
    bl11 = {bounds.b_lower[9], bounds.b_lower};
    bu11 = {bounds.b_upper[9], bounds.b_upper};
    push_data.lightness = lv[6:0];
    push_data.chroma_a  = av[9:0];
    push_data.chroma_b  = bv[8:0];
    push_data.in_range  = (l11 > ll11) && (l11 < lu11) &&
                          (a11 > al11) && (a11 < au11) &&
                          (b11 > bl11) && (b11 < bu11);
  end

  // ix and iz are not used beyond this sink
  logic unused_idx;
  assign unused_idx = ^{ix, iz};

endmodule
`default_nettype wire

@@ rtl/rlt_queue.sv @@
// rlt_queue: short result queue between the classifier pipeline and the output
// depends on rlt_pkg
`default_nettype none
module rlt_queue
  import rlt_pkg::*;
#(
  parameter int Q_DEPTH = RLT_Q_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push_valid,
  output logic          push_ready,
  input  wire rlt_res_t push_data,
  output logic          pop_valid,
  input  wire logic     pop_ready,
  output rlt_res_t      pop_data
);

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  rlt_res_t        mem [Q_DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            push, pop;

  assign push_ready = count_r != CW'(Q_DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(Q_DEPTH))
    else $error("queue count past depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("push lost");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> count_r == $past(count_r) - CW'(1))
    else $error("pop lost");

endmodule
`default_nettype wire

@@ rtl/rgb565_lab_threshold_classifier.sv @@
// Converts each rgb565 pixel to fixed-point cie lab and flags whether L, a and b all lie
// strictly inside six programmable bounds. One pixel is taken per clock unless the
// pipeline is held; each result passes gamma, product and sum stages, the 10-stage
// cube root pipeline of f(t), scaling and the queue. A result queue, two entries
// deep by default, lets output stall without stopping input until it fills. Bounds
// must be written on the cfg port only while no pixel is in flight; it is not checked.
// depends on rlt_pkg, rlt_if, rlt_front, rlt_queue
`default_nettype none
module rgb565_lab_threshold_classifier
  import rlt_pkg::*;
#(
  parameter int Q_DEPTH = RLT_Q_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  rlt_pix_if.sink   in_pix,
  rlt_res_if.source out_res,
  rlt_cfg_if.sink   cfg_wr
);

  rlt_bounds_t bounds_r;
  logic        push_valid, push_ready;
  rlt_res_t    push_data, pop_data;

  assign cfg_wr.ready = 1'b1;

  // bound registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.l_lower <= L_LOWER_RST;
      bounds_r.l_upper <= L_UPPER_RST;
      bounds_r.a_lower <= A_LOWER_RST;
      bounds_r.a_upper <= A_UPPER_RST;
      bounds_r.b_lower <= B_LOWER_RST;
      bounds_r.b_upper <= B_UPPER_RST;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_L_LOWER: bounds_r.l_lower <= cfg_wr.data;
        REG_L_UPPER: bounds_r.l_upper <= cfg_wr.data;
        REG_A_LOWER: bounds_r.a_lower <= cfg_wr.data;
        REG_A_UPPER: bounds_r.a_upper <= cfg_wr.data;
        REG_B_LOWER: bounds_r.b_lower <= cfg_wr.data;
        REG_B_UPPER: bounds_r.b_upper <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  rlt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_pix.valid),
    .in_ready   (in_pix.ready),
    .pixel      (in_pix.pixel_rgb565),
    .bounds     (bounds_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rlt_queue #(.Q_DEPTH(Q_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (out_res.valid),
    .pop_ready  (out_res.ready),
    .pop_data   (pop_data)
  );

  assign out_res.lightness = pop_data.lightness;
  assign out_res.chroma_a  = pop_data.chroma_a;
  assign out_res.chroma_b  = pop_data.chroma_b;
  assign out_res.in_range  = pop_data.in_range;

endmodule
`default_nettype wire
